// ===== src/art_pkg.sv =====
// art_pkg: request and status codes of the allocation range tracker.
// Used by the top level; no dependencies.
package art_pkg;

  localparam logic [1:0] REQ_ALLOC   = 2'd0;
  localparam logic [1:0] REQ_FREE    = 2'd1;
  localparam logic [1:0] REQ_REALLOC = 2'd2;
  localparam logic [1:0] REQ_CHECK   = 2'd3;

  localparam logic [3:0] ST_OK            = 4'd0;
  localparam logic [3:0] ST_DOUBLE        = 4'd1;
  localparam logic [3:0] ST_NOTFIRST      = 4'd2;
  localparam logic [3:0] ST_UNTRACKED     = 4'd3;
  localparam logic [3:0] ST_REALLOC_FREED = 4'd4;
  localparam logic [3:0] ST_RANGE_FREED   = 4'd5;
  localparam logic [3:0] ST_OUTSIDE       = 4'd6;
  localparam logic [3:0] ST_FULL          = 4'd7;
  localparam logic [3:0] ST_ZERO          = 4'd8;

endpackage

// ===== src/art_ram.sv =====
// art_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module art_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/art_scan.sv =====
// art_scan: shared table scan unit. One pass reads every entry from the range RAM
// and finds the exact-base entry, the closest base below the key and a free slot.
// Depends on nothing but the RAM it drives.
module art_scan #(
  parameter int ENTRIES   = 64,
  parameter int ADDR_BITS = 32
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [ADDR_BITS-1:0]       key,
  input  logic [ENTRIES-1:0]         valid,
  output logic [$clog2(ENTRIES)-1:0] raddr,
  input  logic [2*ADDR_BITS-1:0]     rdata,
  output logic                       done,
  output logic                       ex_hit,
  output logic [$clog2(ENTRIES)-1:0] ex_idx,
  output logic                       found_hit,
  output logic [$clog2(ENTRIES)-1:0] found_idx,
  output logic [ADDR_BITS-1:0]       found_base,
  output logic [ADDR_BITS-1:0]       found_len,
  output logic                       free_hit,
  output logic [$clog2(ENTRIES)-1:0] free_idx
);

  localparam int IW = $clog2(ENTRIES);

  logic                 busy;
  logic [IW:0]          cnt;
  logic                 rd_pend;
  logic [IW-1:0]        rd_idx;
  logic [ADDR_BITS-1:0] key_r;
  logic [ADDR_BITS-1:0] ex_len;
  logic                 bh;
  logic [IW-1:0]        bi;
  logic [ADDR_BITS-1:0] bb;
  logic [ADDR_BITS-1:0] bl;
  logic [ADDR_BITS-1:0] r_base;
  logic [ADDR_BITS-1:0] r_len;
  logic [ADDR_BITS-1:0] key_off;
  logic                 r_v;

  assign raddr   = cnt[IW-1:0];
  assign r_base  = rdata[2*ADDR_BITS-1:ADDR_BITS];
  assign r_len   = rdata[ADDR_BITS-1:0];
  assign r_v     = valid[rd_idx];
  assign key_off = key_r - bb;

  assign found_hit  = ex_hit || (bh && (key_off < bl));
  assign found_idx  = ex_hit ? ex_idx : bi;
  assign found_base = ex_hit ? key_r : bb;
  assign found_len  = ex_hit ? ex_len : bl;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy    <= 1'b0;
      done    <= 1'b0;
      rd_pend <= 1'b0;
      cnt     <= '0;
    end else begin
      // done lasts one cycle; busy is already low then
      if (done) begin
        done <= 1'b0;
      end
      if (start) begin
        busy     <= 1'b1;
        cnt      <= '0;
        rd_pend  <= 1'b0;
        key_r    <= key;
        ex_hit   <= 1'b0;
        bh       <= 1'b0;
        free_hit <= 1'b0;
      end else if (busy) begin
        // issue the next read while the previous entry is compared
        if (cnt < (IW+1)'(ENTRIES)) begin
          rd_pend <= 1'b1;
          rd_idx  <= cnt[IW-1:0];
          cnt     <= cnt + 1'b1;
        end else begin
          rd_pend <= 1'b0;
          if (!rd_pend) begin
            busy <= 1'b0;
            done <= 1'b1;
          end
        end
        if (rd_pend) begin
          if (r_v && r_base == key_r && !ex_hit) begin
            ex_hit <= 1'b1;
            ex_idx <= rd_idx;
            ex_len <= r_len;
          end
          if (r_v && r_base < key_r && (!bh || r_base > bb)) begin
            bh <= 1'b1;
            bi <= rd_idx;
            bb <= r_base;
            bl <= r_len;
          end
          if (!r_v && !free_hit) begin
            free_hit <= 1'b1;
            free_idx <= rd_idx;
          end
        end
      end
    end
  end

endmodule

// ===== src/allocation_range_tracker.sv =====
// allocation_range_tracker: table of tracked address ranges with allocate, free,
// reallocate and range-check requests. Uses art_pkg, art_ram and art_scan.
//
//   channel | handshake            | payload
//   --------+----------------------+----------------------------------------
//   request | in_valid / in_ready  | req_type, ptr, byte_count, base
//   result  | out_valid / out_ready| status, result_addr
//
// Every table search is one pass of the shared scan unit over the range RAM.
// Free takes one pass, reallocate and check one or two, allocate three or
// four (a null-pointer reallocate runs as allocate); after the last pass the
// result is loaded into the output register.
// in_ready is high only while the sequencer idles; a finished result sits in
// the output register and the next transaction may enter meanwhile.
// Reset clears the valid and freed bits at once; no clearing pass is needed.
module allocation_range_tracker #(
  parameter int ENTRIES   = 64,
  parameter int ADDR_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  req_type,
  input  logic [31:0] ptr,
  input  logic [31:0] byte_count,
  input  logic [31:0] base,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  status,
  output logic [31:0] result_addr
);

  localparam int IW = $clog2(ENTRIES);
  localparam int AB = ADDR_BITS;

  typedef enum logic [3:0] {
    S_IDLE, S_A1, S_A2, S_A3, S_A4, S_FR, S_RE, S_RM, S_C1, S_C2, S_FIN
  } state_t;

  state_t state;

  // masked request fields
  logic [63:0]   ptr64, cnt64, base64, res64;
  logic [AB-1:0] p, sz, nb;
  logic [AB-1:0] p_in, sz_in, nb_in;
  logic [1:0]    rq;

  logic [ENTRIES-1:0] valid, freed;

  logic [IW-1:0] jreg;
  logic [AB-1:0] mv_len;
  logic [3:0]    st_r;
  logic [AB-1:0] res_r;

  // scan and RAM signals
  logic          scan_start;
  logic [AB-1:0] scan_key;
  logic [IW-1:0] raddr;
  logic [2*AB-1:0] rdata;
  logic          done, ex_hit, found_hit, free_hit;
  logic [IW-1:0] ex_idx, found_idx, free_idx;
  logic [AB-1:0] found_base, found_len;
  logic          ram_we;
  logic [IW-1:0] ram_waddr;
  logic [2*AB-1:0] ram_wdata;

  assign ptr64  = {32'b0, ptr};
  assign cnt64  = {32'b0, byte_count};
  assign base64 = {32'b0, base};
  assign p_in   = ptr64[AB-1:0];
  assign sz_in  = cnt64[AB-1:0];
  assign nb_in  = base64[AB-1:0];
  assign res64  = 64'(res_r);

  assign in_ready = (state == S_IDLE);

  art_ram #(.WIDTH(2*AB), .DEPTH(ENTRIES)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  art_scan #(.ENTRIES(ENTRIES), .ADDR_BITS(AB)) u_scan (
    .clk        (clk),
    .rst        (rst),
    .start      (scan_start),
    .key        (scan_key),
    .valid      (valid),
    .raddr      (raddr),
    .rdata      (rdata),
    .done       (done),
    .ex_hit     (ex_hit),
    .ex_idx     (ex_idx),
    .found_hit  (found_hit),
    .found_idx  (found_idx),
    .found_base (found_base),
    .found_len  (found_len),
    .free_hit   (free_hit),
    .free_idx   (free_idx)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      out_valid  <= 1'b0;
      scan_start <= 1'b0;
      ram_we     <= 1'b0;
      valid      <= '0;
      freed      <= '0;
    end else begin
      // start and write strobes last one cycle; no state raises them back to back
      if (scan_start) begin
        scan_start <= 1'b0;
      end
      if (ram_we) begin
        ram_we <= 1'b0;
      end
      // drop a taken result unless a new one is loaded in the same cycle
      if (out_valid && out_ready && state != S_FIN) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            rq         <= req_type;
            p          <= p_in;
            sz         <= sz_in;
            nb         <= nb_in;
            scan_start <= 1'b1;
            // null-pointer reallocate behaves as allocate
            if (req_type == art_pkg::REQ_ALLOC ||
                (req_type == art_pkg::REQ_REALLOC && p_in == '0)) begin
              scan_key <= nb_in;
              state    <= S_A1;
            end else if (req_type == art_pkg::REQ_FREE ||
                         (req_type == art_pkg::REQ_REALLOC && sz_in == '0)) begin
              scan_key <= p_in;
              state    <= S_FR;
            end else if (req_type == art_pkg::REQ_REALLOC) begin
              scan_key <= p_in;
              state    <= S_RE;
            end else begin
              scan_key <= p_in;
              state    <= S_C1;
            end
          end
        end
        S_A1: begin
          if (done) begin
            if (found_hit) begin
              // trim a freed range holding the first byte
              if (freed[found_idx]) begin
                ram_we    <= 1'b1;
                ram_waddr <= found_idx;
                ram_wdata <= {found_base, nb - found_base};
              end
              if (found_base == nb) begin
                valid[found_idx] <= 1'b0;
                freed[found_idx] <= 1'b0;
              end
            end
            scan_start <= 1'b1;
            scan_key   <= nb + sz - 1'b1;
            state      <= S_A2;
          end
        end
        S_A2: begin
          if (done) begin
            scan_start <= 1'b1;
            if (found_hit && freed[found_idx]) begin
              // freed range holding the last byte moves past the new range
              jreg     <= found_idx;
              mv_len   <= found_base + found_len - (nb + sz);
              scan_key <= nb + sz;
              state    <= S_A3;
            end else begin
              scan_key <= nb;
              state    <= S_A4;
            end
          end
        end
        S_A3: begin
          if (done) begin
            if (ex_hit && ex_idx != jreg) begin
              valid[ex_idx] <= 1'b0;
              freed[ex_idx] <= 1'b0;
            end
            ram_we     <= 1'b1;
            ram_waddr  <= jreg;
            ram_wdata  <= {nb + sz, mv_len};
            scan_start <= 1'b1;
            scan_key   <= nb;
            state      <= S_A4;
          end
        end
        S_A4: begin
          if (done) begin
            res_r <= nb;
            state <= S_FIN;
            if (ex_hit || free_hit) begin
              valid[ex_hit ? ex_idx : free_idx] <= 1'b1;
              freed[ex_hit ? ex_idx : free_idx] <= 1'b0;
              ram_we    <= 1'b1;
              ram_waddr <= ex_hit ? ex_idx : free_idx;
              ram_wdata <= {nb, sz};
              st_r      <= (sz == '0) ? art_pkg::ST_ZERO : art_pkg::ST_OK;
            end else begin
              st_r <= art_pkg::ST_FULL;
            end
          end
        end
        S_FR: begin
          if (done) begin
            res_r <= '0;
            state <= S_FIN;
            if (ex_hit) begin
              if (freed[ex_idx]) begin
                st_r <= art_pkg::ST_DOUBLE;
              end else begin
                freed[ex_idx] <= 1'b1;
                st_r <= (rq == art_pkg::REQ_REALLOC) ? art_pkg::ST_ZERO : art_pkg::ST_OK;
              end
            end else begin
              st_r <= found_hit ? art_pkg::ST_NOTFIRST : art_pkg::ST_UNTRACKED;
            end
          end
        end
        S_RE: begin
          if (done) begin
            if (!ex_hit) begin
              st_r  <= art_pkg::ST_NOTFIRST;
              res_r <= '0;
              state <= S_FIN;
            end else if (freed[ex_idx]) begin
              st_r  <= art_pkg::ST_REALLOC_FREED;
              res_r <= '0;
              state <= S_FIN;
            end else if (nb != p) begin
              jreg       <= ex_idx;
              scan_start <= 1'b1;
              scan_key   <= nb;
              state      <= S_RM;
            end else begin
              ram_we    <= 1'b1;
              ram_waddr <= ex_idx;
              ram_wdata <= {p, sz};
              st_r      <= art_pkg::ST_OK;
              res_r     <= nb;
              state     <= S_FIN;
            end
          end
        end
        S_RM: begin
          if (done) begin
            // drop whatever entry already sits at the new base
            if (ex_hit && ex_idx != jreg) begin
              valid[ex_idx] <= 1'b0;
              freed[ex_idx] <= 1'b0;
            end
            ram_we    <= 1'b1;
            ram_waddr <= jreg;
            ram_wdata <= {nb, sz};
            st_r      <= art_pkg::ST_OK;
            res_r     <= nb;
            state     <= S_FIN;
          end
        end
        S_C1: begin
          if (done) begin
            if (!found_hit) begin
              st_r  <= art_pkg::ST_OUTSIDE;
              res_r <= '0;
              state <= S_FIN;
            end else begin
              jreg       <= found_idx;
              scan_start <= 1'b1;
              scan_key   <= p + sz - 1'b1;
              state      <= S_C2;
            end
          end
        end
        S_C2: begin
          if (done) begin
            res_r <= '0;
            state <= S_FIN;
            if (found_hit && found_idx == jreg) begin
              st_r <= freed[jreg] ? art_pkg::ST_RANGE_FREED : art_pkg::ST_OK;
            end else begin
              st_r <= art_pkg::ST_OUTSIDE;
            end
          end
        end
        S_FIN: begin
          // hold until the output register is free
          if (!out_valid || out_ready) begin
            out_valid   <= 1'b1;
            status      <= st_r;
            result_addr <= res64[31:0];
            state       <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
